// ===== rtl/core/hbbc_pkg.sv =====
// Package for the hashed block buffer cache: sizes, command and status codes,
// and the records for commands (front end to back end) and for results.
// No dependencies.
package hbbc_pkg;

  localparam int unsigned NumBuffersDefault = 32;
  localparam int unsigned NumBucketsDefault = 13;

  localparam logic [1:0] CMD_GET     = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_PIN     = 2'd2;
  localparam logic [1:0] CMD_UNPIN   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_COUNT    = 2'd2;

  localparam logic [7:0] COUNT_MAX   = 8'hFF;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  buffer_index;
    logic [31:0] now_tick;
    logic [3:0]  home;
  } cmd_t;

  typedef struct packed {
    logic [4:0] granted_buffer;
    logic       was_hit;
    logic       needs_read;
    logic [1:0] status;
  } res_t;

endpackage

// ===== rtl/core/hbbc_front.sv =====
// Front end: accepts transactions, reduces the block number to its home bucket
// four bits per cycle with a reciprocal multiplication, and queues the command.
// Depends on hbbc_pkg.
module hbbc_front #(
  parameter int unsigned NUM_BUCKETS = hbbc_pkg::NumBucketsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic [7:0]        in_device,
  input  logic [31:0]       in_block_number,
  input  logic [4:0]        in_buffer_index,
  input  logic [31:0]       in_now_tick,
  output logic              q_valid,
  input  logic              q_ready,
  output hbbc_pkg::cmd_t    q_data
);
  import hbbc_pkg::*;

  localparam logic [7:0]  Nb   = 8'(NUM_BUCKETS);
  localparam logic [16:0] RMul = 17'((65536 + NUM_BUCKETS - 1) / NUM_BUCKETS);

  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [3:0]  rem_r, rem_nxt;
  cmd_t        cur_r, cur_nxt;
  logic        fifo_full;
  logic        push;
  logic [4:0]  sel;
  logic [7:0]  acc;
  logic [24:0] prod;
  logic [7:0]  quo;
  logic [7:0]  red;

  cmd_t        fifo_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;

  assign in_ready  = !busy_r;
  assign fifo_full = (cnt_r == 2'd2);
  assign push      = busy_r && (step_r == 4'd8) && !fifo_full;
  assign sel       = 5'd28 - {step_r[2:0], 2'b00};
  assign acc       = {rem_r, cur_r.block_number[sel +: 4]};
  assign prod      = 25'(acc) * 25'(RMul);
  assign quo       = prod[23:16];
  assign red       = acc - quo * Nb;

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    cur_nxt  = cur_r;
    if (!busy_r) begin
      if (in_valid) begin
        busy_nxt              = 1'b1;
        step_nxt              = 4'd0;
        rem_nxt               = '0;
        cur_nxt.command       = in_command;
        cur_nxt.device        = in_device;
        cur_nxt.block_number  = in_block_number;
        cur_nxt.buffer_index  = in_buffer_index;
        cur_nxt.now_tick      = in_now_tick;
        cur_nxt.home          = '0;
      end
    end else if (step_r != 4'd8) begin
      rem_nxt  = red[3:0];
      step_nxt = step_r + 4'd1;
      if (step_r == 4'd7) begin
        cur_nxt.home = red[3:0];
      end
    end else if (push) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
      wp_r   <= 1'b0;
      rp_r   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      if (push) begin
        wp_r <= !wp_r;
      end
      if (q_valid && q_ready) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_valid && q_ready};
    end
    rem_r <= rem_nxt;
    cur_r <= cur_nxt;
    if (push) begin
      fifo_r[wp_r] <= cur_r;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = fifo_r[rp_r];

endmodule

// ===== rtl/core/hbbc_back.sv =====
// Back end: holds the buffer table and carries out one command at a time,
// scanning one buffer per cycle on a get for tag matches and the oldest free buffers.
// Depends on hbbc_pkg.
module hbbc_back #(
  parameter int unsigned NUM_BUFFERS = hbbc_pkg::NumBuffersDefault,
  parameter int unsigned NUM_BUCKETS = hbbc_pkg::NumBucketsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  hbbc_pkg::cmd_t    q_data,
  output logic              out_valid,
  input  logic              out_ready,
  output hbbc_pkg::res_t    out_data
);
  import hbbc_pkg::*;

  localparam int unsigned IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
  localparam int unsigned CW = $clog2(NUM_BUFFERS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_OUT   = 3'd3;

  logic [7:0]  tag_device_r     [NUM_BUFFERS];
  logic [31:0] tag_block_r      [NUM_BUFFERS];
  logic [7:0]  ref_count_r      [NUM_BUFFERS];
  logic [31:0] last_release_r   [NUM_BUFFERS];
  logic        contents_valid_r [NUM_BUFFERS];
  logic [3:0]  bucket_r         [NUM_BUFFERS];
  logic [31:0] insert_order_r   [NUM_BUFFERS];
  logic [31:0] insert_counter_r;

  logic [2:0]    state_r;
  cmd_t          cmd_r;
  logic [CW-1:0] k_r;
  logic          found_v_r;
  logic [IW-1:0] found_r;
  logic [NUM_BUCKETS-1:0] bv_r;
  logic [IW-1:0] bi_r [NUM_BUCKETS];
  logic [3:0]    j_r;
  res_t          res_r;
  logic          upd_r;
  logic          move_r;
  logic [IW-1:0] pick_r;

  logic [IW-1:0] k;
  logic [3:0]    bk;
  logic [IW-1:0] bb;
  logic [3:0]    jn;
  logic [IW-1:0] idx;
  logic          idx_ok;

  assign k      = k_r[IW-1:0];
  assign bk     = bucket_r[k];
  assign bb     = bi_r[bk];
  assign jn     = (j_r == 4'(NUM_BUCKETS - 1)) ? 4'd0 : j_r + 4'd1;
  assign idx    = IW'(cmd_r.buffer_index);
  assign idx_ok = ({2'b00, cmd_r.buffer_index} < 7'(NUM_BUFFERS));

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data  = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      insert_counter_r <= 32'(NUM_BUFFERS);
      upd_r            <= 1'b0;
      for (int i = 0; i < NUM_BUFFERS; i++) begin
        tag_device_r[i]     <= '0;
        tag_block_r[i]      <= '0;
        ref_count_r[i]      <= '0;
        last_release_r[i]   <= '0;
        contents_valid_r[i] <= 1'b0;
        bucket_r[i]         <= '0;
        insert_order_r[i]   <= 32'(i);
      end
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            cmd_r     <= q_data;
            k_r       <= '0;
            found_v_r <= 1'b0;
            bv_r      <= '0;
            res_r     <= '0;
            state_r   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (cmd_r.command != CMD_GET) begin
            res_r.granted_buffer <= cmd_r.buffer_index;
            if (idx_ok) begin
              if (cmd_r.command == CMD_PIN) begin
                if (ref_count_r[idx] == COUNT_MAX) begin
                  res_r.status <= ST_COUNT;
                end else begin
                  ref_count_r[idx] <= ref_count_r[idx] + 8'd1;
                end
              end else if (ref_count_r[idx] == '0) begin
                res_r.status <= ST_COUNT;
              end else begin
                ref_count_r[idx] <= ref_count_r[idx] - 8'd1;
                if (cmd_r.command == CMD_RELEASE && ref_count_r[idx] == 8'd1) begin
                  last_release_r[idx] <= cmd_r.now_tick;
                end
              end
            end
            state_r <= S_OUT;
          end else if (k_r == CW'(NUM_BUFFERS)) begin
            j_r     <= cmd_r.home;
            state_r <= S_PICK;
          end else begin
            if (bk == cmd_r.home && tag_device_r[k] == cmd_r.device &&
                tag_block_r[k] == cmd_r.block_number &&
                (!found_v_r || insert_order_r[k] > insert_order_r[found_r])) begin
              found_v_r <= 1'b1;
              found_r   <= k;
            end
            if (ref_count_r[k] == '0 && (!bv_r[bk] ||
                last_release_r[k] < last_release_r[bb] ||
                (last_release_r[k] == last_release_r[bb] &&
                 insert_order_r[k] > insert_order_r[bb]))) begin
              bv_r[bk] <= 1'b1;
              bi_r[bk] <= k;
            end
            k_r <= k_r + CW'(1);
          end
        end
        S_PICK: begin
          if (found_v_r) begin
            res_r.granted_buffer <= 5'(found_r);
            res_r.was_hit        <= 1'b1;
            if (ref_count_r[found_r] == COUNT_MAX) begin
              res_r.status <= ST_COUNT;
            end else begin
              res_r.needs_read          <= !contents_valid_r[found_r];
              contents_valid_r[found_r] <= 1'b1;
              ref_count_r[found_r]      <= ref_count_r[found_r] + 8'd1;
            end
            state_r <= S_OUT;
          end else if (bv_r[j_r]) begin
            pick_r  <= bi_r[j_r];
            move_r  <= (j_r != cmd_r.home);
            upd_r   <= 1'b1;
            res_r.granted_buffer <= 5'(bi_r[j_r]);
            res_r.needs_read     <= 1'b1;
            state_r <= S_OUT;
          end else if (jn == cmd_r.home) begin
            res_r.status <= ST_NO_FREE;
            state_r      <= S_OUT;
          end else begin
            j_r <= jn;
          end
        end
        S_OUT: begin
          if (upd_r) begin
            upd_r                    <= 1'b0;
            tag_device_r[pick_r]     <= cmd_r.device;
            tag_block_r[pick_r]      <= cmd_r.block_number;
            ref_count_r[pick_r]      <= 8'd1;
            contents_valid_r[pick_r] <= 1'b1;
            if (move_r) begin
              bucket_r[pick_r]       <= cmd_r.home;
              insert_order_r[pick_r] <= insert_counter_r;
              insert_counter_r       <= insert_counter_r + 32'd1;
            end
          end
          if (out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/hashed_block_buffer_cache.sv =====
// Hashed block buffer cache: a front end computing the bucket of each request,
// a two-entry queue, and a back end holding the tag table.
// Depends on hbbc_pkg, hbbc_front and hbbc_back.
//
// Usage: commands (get, release, pin, unpin) arrive on the in_ channel with a
// valid/ready handshake; exactly one result per command leaves on the out_
// channel. The front end reduces the block number modulo the bucket count
// four bits per cycle, then queues the command; it takes no new one before.
// For a get the back end scans one buffer per cycle, then on a miss searches
// the buckets from the home bucket onward for a free buffer; the other
// commands are carried out without a scan. Front and back overlap, so the
// front end can reduce a new command while the back end works on an older one.
// The result is held in a register until taken; while the receiver stalls the
// back end waits and the front end fills the queue, then stops accepting.
// Reset is synchronous, active low, and restores every buffer to the empty
// state in bucket 0 at once.
module hashed_block_buffer_cache #(
  parameter int unsigned NUM_BUFFERS = hbbc_pkg::NumBuffersDefault,
  parameter int unsigned NUM_BUCKETS = hbbc_pkg::NumBucketsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [7:0]  in_device,
  input  logic [31:0] in_block_number,
  input  logic [4:0]  in_buffer_index,
  input  logic [31:0] in_now_tick,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_granted_buffer,
  output logic        out_was_hit,
  output logic        out_needs_read,
  output logic [1:0]  out_status
);
  import hbbc_pkg::*;

  logic q_valid, q_ready;
  cmd_t q_data;
  res_t res;

  hbbc_front #(.NUM_BUCKETS(NUM_BUCKETS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_command, .in_device,
    .in_block_number, .in_buffer_index, .in_now_tick,
    .q_valid, .q_ready, .q_data
  );

  hbbc_back #(.NUM_BUFFERS(NUM_BUFFERS), .NUM_BUCKETS(NUM_BUCKETS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data(res)
  );

  assign out_granted_buffer = res.granted_buffer;
  assign out_was_hit        = res.was_hit;
  assign out_needs_read     = res.needs_read;
  assign out_status         = res.status;

`ifndef SYNTHESIS
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_was_hit |-> out_status != ST_NO_FREE)
    else $error("hit reported with no-free status");
  a_nofree: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_NO_FREE |-> !out_needs_read && out_granted_buffer == 5'd0)
    else $error("failed get carries a buffer");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped while stalled");
`endif

endmodule
